/* src/led_sunrise_sunset_fade_unit_assert.svh */
// Assertion macros shared by the fade unit RTL.
`ifndef LED_SUNRISE_SUNSET_FADE_UNIT_ASSERT_SVH
`define LED_SUNRISE_SUNSET_FADE_UNIT_ASSERT_SVH

// Checked at every clock edge outside reset.
`define LSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define LSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/lsf_pkg.sv */
// Package with the codes, constants and types of the LED fade unit.
`timescale 1ns / 1ps
package lsf_pkg;

  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SCALE_W    = 17;
  // duration (8 bits) times the largest scale (17 bits) fits in 25 bits
  localparam int unsigned DIVIDEND_W = 25;

  localparam logic [SCALE_W-1:0] MS_PER_MIN_SINGLE = 17'd60000;
  localparam logic [SCALE_W-1:0] MS_PER_MIN_BOTH   = 17'd120000;

  // Channel selection codes
  localparam logic [1:0] SEL_WARM = 2'd0;
  localparam logic [1:0] SEL_COLD = 2'd1;
  localparam logic [1:0] SEL_BOTH = 2'd2;
  localparam logic [1:0] SEL_BAD  = 2'd3;

  // Action codes of an input transaction
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_RISE = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Ramp modes
  localparam logic [1:0] MODE_HOLD = 2'd0;
  localparam logic [1:0] MODE_RISE = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SEL   = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;
  localparam logic [1:0] REG_DUR   = 2'd3;

  typedef struct packed {
    logic                    start;
    logic [DIVIDEND_W-1:0]   dividend;
    logic [LEVEL_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [DIVIDEND_W-1:0]   quotient;
  } div_rsp_t;

endpackage

/* src/led_sunrise_sunset_fade_unit.sv */
// Top level of the two-channel LED sunrise and sunset fade unit.
`timescale 1ns / 1ps
// The unit takes one transaction at a time and answers each with exactly one
// result. A tick while a ramp runs passes the delta, accumulate and compare states
// before the result register: the time difference, the saturating accumulation
// and the interval compare each take one pass through the shared 33-bit adder.
// A start waits for the bit-serial divider, which forms the step interval one
// quotient bit per cycle. A rejected start goes from the start check to the
// output state; a tick while static and an ignored action go there directly.
// A new transaction is accepted while the previous result still waits in the
// output register. Configuration must only be written while the unit is idle.
module led_sunrise_sunset_fade_unit import lsf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LEVEL_W-1:0] warm_level_o,
  output logic [LEVEL_W-1:0] cold_level_o,
  output logic [1:0]         ramp_mode_o,
  output logic               light_on_o,
  output logic               step_taken_o,
  output logic               start_rejected_o
);

`include "led_sunrise_sunset_fade_unit_assert.svh"

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_DELTA = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_CMP   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [1:0]         reg_sel_q;
  logic [LEVEL_W-1:0] reg_start_q, reg_end_q, reg_dur_q;

  // Fade state
  logic [31:0]           last_q, last_d;
  logic [31:0]           acc_q, acc_d;
  logic [DIVIDEND_W-1:0] interval_q, interval_d;
  logic [LEVEL_W-1:0]    warm_q, warm_d, cold_q, cold_d, tgt_q, tgt_d;
  logic [1:0]            mode_q, mode_d, sel_q, sel_d;
  logic                  on_q, on_d;

  // Transaction in flight
  logic [1:0]  action_q, action_d;
  logic [31:0] now_q, now_d;
  logic [31:0] delta_q, delta_d;
  logic        step_q, step_d, rej_q, rej_d;

  // Output register
  logic               out_valid_q, out_valid_d, out_load;
  logic [LEVEL_W-1:0] out_warm_q, out_cold_q;
  logic [1:0]         out_mode_q;
  logic               out_on_q, out_step_q, out_rej_q;

  // Shared adder
  logic [31:0] alu_a, alu_b;
  logic        alu_sub;
  logic [32:0] alu_res;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               is_rise, start_ok;
  logic [LEVEL_W-1:0] gap;
  logic [SCALE_W-1:0] scale;

  logic               use_w, use_c;
  logic [LEVEL_W-1:0] warm_st, cold_st;
  logic [1:0]         mode_st;
  logic               on_st;

  lsf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_sel_q   <= SEL_WARM;
      reg_start_q <= '0;
      reg_end_q   <= '0;
      reg_dur_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SEL:   reg_sel_q   <= cfg_wdata_i[1:0];
        REG_START: reg_start_q <= cfg_wdata_i;
        REG_END:   reg_end_q   <= cfg_wdata_i;
        REG_DUR:   reg_dur_q   <= cfg_wdata_i;
        default:   reg_sel_q   <= reg_sel_q;
      endcase
    end
  end

  always_comb begin
    alu_a   = acc_q;
    alu_b   = 32'(interval_q);
    alu_sub = 1'b1;
    unique case (state_q)
      S_DELTA: begin
        alu_a = now_q;
        alu_b = last_q;
      end
      S_ACC: begin
        alu_b   = delta_q;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = acc_q;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
  end

  assign is_rise  = (action_q == ACT_RISE);
  assign start_ok = (reg_sel_q != SEL_BAD) &&
                    (is_rise ? (reg_end_q > reg_start_q) : (reg_start_q > reg_end_q));
  assign gap      = is_rise ? (reg_end_q - reg_start_q) : (reg_start_q - reg_end_q);
  assign scale    = (reg_sel_q == SEL_BOTH) ? MS_PER_MIN_BOTH : MS_PER_MIN_SINGLE;

  // One level step toward the target; in both mode the warm channel decides the end.
  always_comb begin
    use_w   = (sel_q == SEL_WARM) || (sel_q == SEL_BOTH);
    use_c   = (sel_q == SEL_COLD) || (sel_q == SEL_BOTH);
    warm_st = warm_q;
    cold_st = cold_q;
    mode_st = mode_q;
    on_st   = on_q;
    if (!on_q) begin
      mode_st = MODE_HOLD;
    end else if (mode_q == MODE_RISE) begin
      if (use_w && (warm_q < tgt_q)) warm_st = warm_q + LEVEL_W'(1);
      if (use_c && (cold_q < tgt_q)) cold_st = cold_q + LEVEL_W'(1);
      if (use_w) begin
        if (warm_st >= tgt_q) begin
          mode_st = MODE_HOLD;
          if (sel_q == SEL_WARM) cold_st = '0;
        end
      end else if (sel_q == SEL_COLD) begin
        if (cold_st >= tgt_q) begin
          mode_st = MODE_HOLD;
          warm_st = '0;
        end
      end
    end else begin
      if (use_w && (warm_q > tgt_q)) warm_st = warm_q - LEVEL_W'(1);
      if (use_c && (cold_q > tgt_q)) cold_st = cold_q - LEVEL_W'(1);
      if (use_w) begin
        if (warm_st == '0) begin
          on_st   = 1'b0;
          mode_st = MODE_HOLD;
        end else if (warm_st <= tgt_q) begin
          mode_st = MODE_HOLD;
          if (sel_q == SEL_WARM) cold_st = '0;
        end
      end else if (sel_q == SEL_COLD) begin
        if (cold_st == '0) begin
          on_st   = 1'b0;
          mode_st = MODE_HOLD;
        end else if (cold_st <= tgt_q) begin
          mode_st = MODE_HOLD;
        end
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    acc_d      = acc_q;
    interval_d = interval_q;
    warm_d     = warm_q;
    cold_d     = cold_q;
    tgt_d      = tgt_q;
    mode_d     = mode_q;
    sel_d      = sel_q;
    on_d       = on_q;
    action_d   = action_q;
    now_d      = now_q;
    delta_d    = delta_q;
    step_d     = step_q;
    rej_d      = rej_q;
    div_req.start    = 1'b0;
    div_req.dividend = DIVIDEND_W'(reg_dur_q) * DIVIDEND_W'(scale);
    div_req.divisor  = gap;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          action_d = action_i;
          now_d    = now_ms_i;
          step_d   = 1'b0;
          rej_d    = 1'b0;
          case (action_i) inside
            ACT_RISE, ACT_SET: state_d = S_START;
            ACT_TICK:          state_d = (mode_q != MODE_HOLD) ? S_DELTA : S_OUT;
            default:           state_d = S_OUT;
          endcase
        end
      end
      S_START: begin
        if (!start_ok) begin
          rej_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          sel_d = reg_sel_q;
          unique case (reg_sel_q)
            SEL_WARM: begin
              warm_d = reg_start_q;
              cold_d = '0;
              tgt_d  = reg_end_q;
            end
            SEL_COLD: begin
              warm_d = '0;
              cold_d = reg_start_q;
              tgt_d  = reg_end_q;
            end
            default: begin
              warm_d = reg_start_q >> 1;
              cold_d = reg_start_q >> 1;
              tgt_d  = reg_end_q >> 1;
            end
          endcase
          on_d          = 1'b1;
          mode_d        = is_rise ? MODE_RISE : MODE_SET;
          last_d        = now_q;
          acc_d         = '0;
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          interval_d = div_rsp.quotient;
          state_d    = S_OUT;
        end
      end
      S_DELTA: begin
        delta_d = alu_res[31:0];
        last_d  = now_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        // The accumulator saturates instead of wrapping.
        acc_d   = alu_res[32] ? '1 : alu_res[31:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!alu_res[32]) begin
          acc_d  = '0;
          step_d = 1'b1;
          warm_d = warm_st;
          cold_d = cold_st;
          mode_d = mode_st;
          on_d   = on_st;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      acc_q       <= '0;
      interval_q  <= '0;
      warm_q      <= '0;
      cold_q      <= '0;
      tgt_q       <= '0;
      mode_q      <= MODE_HOLD;
      sel_q       <= SEL_WARM;
      on_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      acc_q       <= acc_d;
      interval_q  <= interval_d;
      warm_q      <= warm_d;
      cold_q      <= cold_d;
      tgt_q       <= tgt_d;
      mode_q      <= mode_d;
      sel_q       <= sel_d;
      on_q        <= on_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    now_q    <= now_d;
    delta_q  <= delta_d;
    step_q   <= step_d;
    rej_q    <= rej_d;
    if (out_load) begin
      out_warm_q <= warm_q;
      out_cold_q <= cold_q;
      out_mode_q <= mode_q;
      out_on_q   <= on_q;
      out_step_q <= step_q;
      out_rej_q  <= rej_q;
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign warm_level_o     = out_warm_q;
  assign cold_level_o     = out_cold_q;
  assign ramp_mode_o      = out_mode_q;
  assign light_on_o       = out_on_q;
  assign step_taken_o     = out_step_q;
  assign start_rejected_o = out_rej_q;

  `LSF_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_rsp.done |-> (state_q == S_DIV), "divider finished outside the division state")
  `LSF_ASSERT(a_ramp_needs_light, clk_i, rst_ni, (mode_q != MODE_HOLD) |-> on_q, "ramp running with the light off")
  `LSF_ASSERT(a_out_from_out_state, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_OUT), "result raised outside the output state")
  `LSF_ASSERT(a_flags_exclusive, clk_i, rst_ni, out_valid_q |-> !(out_step_q && out_rej_q), "step and rejection flagged together")
  `LSF_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_q, "result valid during reset")

endmodule

/* src/lsf_div.sv */
// Bit-serial restoring divider for the fade step interval.
`timescale 1ns / 1ps
module lsf_div import lsf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [LEVEL_W-1:0]    rem_q, rem_d;
  logic [LEVEL_W-1:0]    dsr_q, dsr_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;

  logic [LEVEL_W:0]      trial;
  logic [LEVEL_W+1:0]    diff;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W - 1);
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      if (!diff[LEVEL_W+1]) begin
        rem_d = diff[LEVEL_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = trial[LEVEL_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* tb/sv/led_sunrise_sunset_fade_checker.sv */
// Checker for the LED fade unit: predicts every result and compares it with the output.
`timescale 1ns / 1ps
module led_sunrise_sunset_fade_checker import lsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] now_ms_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  warm_level_i,
  input  logic [7:0]  cold_level_i,
  input  logic [1:0]  ramp_mode_i,
  input  logic        light_on_i,
  input  logic        step_taken_i,
  input  logic        start_rejected_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] warm;
    logic [7:0] cold;
    logic [1:0] mode;
    logic       lit;
    logic       stepped;
    logic       rejected;
  } fade_result_t;

  // Register copies, written as the unit sees them
  logic [1:0]  cfg_sel;
  logic [7:0]  cfg_start;
  logic [7:0]  cfg_end;
  logic [7:0]  cfg_dur;

  // Fade state
  logic [31:0] last_ms;
  logic [31:0] acc_ms;
  logic [31:0] interval_ms;
  logic [7:0]  warm_q;
  logic [7:0]  cold_q;
  logic [7:0]  goal_q;
  logic [1:0]  mode_q;
  logic [1:0]  sel_q;
  logic        lit_q;

  fade_result_t levels_due[$];
  int           fails;

  function automatic fade_result_t next_fade(input logic [1:0] act, input logic [31:0] now);
    fade_result_t res;
    logic [7:0]   gap;
    logic [31:0]  span;
    logic [32:0]  sum;
    logic         go;
    logic         w;
    logic         c;
    res = '0;
    if (act == ACT_RISE || act == ACT_SET) begin
      go = (cfg_sel != SEL_BAD) &&
           ((act == ACT_RISE) ? (cfg_end > cfg_start) : (cfg_start > cfg_end));
      if (go) begin
        gap  = (act == ACT_RISE) ? cfg_end - cfg_start : cfg_start - cfg_end;
        span = {24'd0, cfg_dur} *
               ((cfg_sel == SEL_BOTH) ? 32'(MS_PER_MIN_BOTH) : 32'(MS_PER_MIN_SINGLE));
        sel_q = cfg_sel;
        case (cfg_sel)
          SEL_WARM: begin
            warm_q = cfg_start;
            cold_q = '0;
            goal_q = cfg_end;
          end
          SEL_COLD: begin
            cold_q = cfg_start;
            warm_q = '0;
            goal_q = cfg_end;
          end
          default: begin
            warm_q = cfg_start >> 1;
            cold_q = cfg_start >> 1;
            goal_q = cfg_end >> 1;
          end
        endcase
        // The interval is taken from the unhalved gap, even in both-channel mode.
        interval_ms = span / {24'd0, gap};
        lit_q  = 1'b1;
        mode_q = (act == ACT_RISE) ? MODE_RISE : MODE_SET;
        last_ms = now;
        acc_ms  = '0;
      end else begin
        res.rejected = 1'b1;
      end
    end else if (act == ACT_TICK && mode_q != MODE_HOLD) begin
      sum     = {1'b0, acc_ms} + {1'b0, now - last_ms};
      acc_ms  = sum[32] ? '1 : sum[31:0];
      last_ms = now;
      if (acc_ms >= interval_ms) begin
        acc_ms      = '0;
        res.stepped = 1'b1;
        w = (sel_q == SEL_WARM || sel_q == SEL_BOTH);
        c = (sel_q == SEL_COLD || sel_q == SEL_BOTH);
        if (!lit_q) begin
          mode_q = MODE_HOLD;
        end else if (mode_q == MODE_RISE) begin
          if (w && warm_q < goal_q) warm_q = warm_q + 8'd1;
          if (c && cold_q < goal_q) cold_q = cold_q + 8'd1;
          // In both-channel mode the warm channel alone decides the end.
          if (w) begin
            if (warm_q >= goal_q) begin
              mode_q = MODE_HOLD;
              if (sel_q == SEL_WARM) cold_q = '0;
            end
          end else if (sel_q == SEL_COLD) begin
            if (cold_q >= goal_q) begin
              mode_q = MODE_HOLD;
              warm_q = '0;
            end
          end
        end else begin
          if (w && warm_q > goal_q) warm_q = warm_q - 8'd1;
          if (c && cold_q > goal_q) cold_q = cold_q - 8'd1;
          if (w) begin
            if (warm_q == '0) begin
              lit_q  = 1'b0;
              mode_q = MODE_HOLD;
            end else if (warm_q <= goal_q) begin
              mode_q = MODE_HOLD;
              if (sel_q == SEL_WARM) cold_q = '0;
            end
          end else if (sel_q == SEL_COLD) begin
            if (cold_q == '0) begin
              lit_q  = 1'b0;
              mode_q = MODE_HOLD;
            end else if (cold_q <= goal_q) begin
              mode_q = MODE_HOLD;
            end
          end
        end
      end
    end
    res.warm = warm_q;
    res.cold = cold_q;
    res.mode = mode_q;
    res.lit  = lit_q;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fade_result_t want;
    if (!rst_ni) begin
      cfg_sel      = SEL_WARM;
      cfg_start    = '0;
      cfg_end      = '0;
      cfg_dur      = '0;
      last_ms      = '0;
      acc_ms       = '0;
      interval_ms  = '0;
      warm_q       = '0;
      cold_q       = '0;
      goal_q       = '0;
      mode_q       = MODE_HOLD;
      sel_q        = SEL_WARM;
      lit_q        = 1'b0;
      fails        = 0;
      levels_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEL:   cfg_sel   = cfg_wdata_i[1:0];
          REG_START: cfg_start = cfg_wdata_i;
          REG_END:   cfg_end   = cfg_wdata_i;
          default:   cfg_dur   = cfg_wdata_i;
        endcase
      end
      if (in_valid_i && in_ready_i) levels_due.push_back(next_fade(action_i, now_ms_i));
      if (out_valid_i && out_ready_i) begin
        if (levels_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d %0d %0d",
                   $time, warm_level_i, cold_level_i, ramp_mode_i, light_on_i,
                   step_taken_i, start_rejected_i);
          fails++;
        end else begin
          want = levels_due.pop_front();
          check_field("warm_level", 32'(want.warm), 32'(warm_level_i));
          check_field("cold_level", 32'(want.cold), 32'(cold_level_i));
          check_field("ramp_mode", 32'(want.mode), 32'(ramp_mode_i));
          check_field("light_on", 32'(want.lit), 32'(light_on_i));
          check_field("step_taken", 32'(want.stepped), 32'(step_taken_i));
          check_field("start_rejected", 32'(want.rejected), 32'(start_rejected_i));
        end
      end
      fail_count_o <= fails;
      pending_o    <= levels_due.size();
    end
  end

endmodule

/* tb/sv/tb_led_sunrise_sunset_fade_unit.sv */
// Testbench top of the LED fade unit: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module tb_led_sunrise_sunset_fade_unit;
  import lsf_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned ITEM_TARGET   = 650;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [31:0] now_ms_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  warm_level_o;
  logic [7:0]  cold_level_o;
  logic [1:0]  ramp_mode_o;
  logic        light_on_o;
  logic        step_taken_o;
  logic        start_rejected_o;

  int          fail_count;
  int          pending;
  int          sent = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;         // no idling on either side while set
  bit          hold_wanted = 1'b0;  // asks the receiver for one long hold-off
  logic [31:0] clock_ms = '0;

  led_sunrise_sunset_fade_unit DUT (.*);

  led_sunrise_sunset_fade_checker u_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .action_i,
    .now_ms_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .warm_level_i    (warm_level_o),
    .cold_level_i    (cold_level_o),
    .ramp_mode_i     (ramp_mode_o),
    .light_on_i      (light_on_o),
    .step_taken_i    (step_taken_o),
    .start_rejected_i(start_rejected_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Tick spacing around the expected step interval, so that ramps make progress.
  function automatic logic [31:0] pick_delta(input logic [31:0] est);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return est + $urandom_range(0, 3);
    if (r < 65) return $urandom_range(0, est);
    if (r < 75) return '0;
    if (r < 83) return est >> 1;
    if (r < 93) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(0, 4);
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [31:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    now_ms_i   <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    if (act != ACT_NONE) sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] sel, input logic [7:0] lvl_from,
                              input logic [7:0] lvl_to, input logic [7:0] minutes);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SEL;
    cfg_wdata_i <= {6'd0, sel};
    @(posedge clk_i);
    cfg_idx_i   <= REG_START;
    cfg_wdata_i <= lvl_from;
    @(posedge clk_i);
    cfg_idx_i   <= REG_END;
    cfg_wdata_i <= lvl_to;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DUR;
    cfg_wdata_i <= minutes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int phase_no);
    logic [1:0]  sel;
    logic [1:0]  dir;
    logic [1:0]  start_act;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  minutes;
    logic [31:0] est;
    int          n_ticks;
    int          r;
    r   = $urandom_range(0, 99);
    sel = (r < 5) ? SEL_BAD : 2'($urandom_range(0, 2));
    dir = $urandom_range(0, 1) ? ACT_RISE : ACT_SET;
    r   = $urandom_range(0, 99);
    if (r < 70) begin
      lo = 8'($urandom_range(0, 243));
      hi = lo + 8'($urandom_range(1, 12));
    end else if (r < 80) begin
      lo = 8'd0;
      hi = 8'd255;
    end else begin
      lo = 8'($urandom());
      hi = 8'($urandom());
      if (lo > hi) begin
        lo = lo ^ hi;
        hi = lo ^ hi;
        lo = lo ^ hi;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 40) minutes = 8'($urandom_range(0, 2));
    else if (r < 70) minutes = 8'($urandom_range(3, 20));
    else if (r < 85) minutes = 8'($urandom());
    else if (r < 92) minutes = 8'd0;
    else minutes = 8'd255;
    est = (hi == lo) ? '0 :
          ({24'd0, minutes} * ((sel == SEL_BOTH) ? 32'd120000 : 32'd60000)) / {24'd0, hi - lo};
    n_ticks = (hi - lo) * 3 / 2 + 4;
    if (n_ticks > 60) n_ticks = 60;
    // Now and then the start runs the wrong way and must be refused.
    start_act = dir;
    if ($urandom_range(0, 99) < 12) start_act = (dir == ACT_RISE) ? ACT_SET : ACT_RISE;
    calm = ($urandom_range(0, 4) == 0);
    if (dir == ACT_RISE) write_config(sel, lo, hi, minutes);
    else write_config(sel, hi, lo, minutes);
    if (phase_no == 3) begin
      calm        = 1'b1;
      hold_wanted = 1'b1;
      n_ticks     = 60;
    end
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 5000);
    send_item(start_act, clock_ms);
    repeat (n_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_item(ACT_NONE, $urandom());
      end else if (r < 7) begin
        send_item($urandom_range(0, 1) ? ACT_RISE : ACT_SET, clock_ms);
      end else begin
        clock_ms = clock_ms + pick_delta(est);
        send_item(ACT_TICK, clock_ms);
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_no;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_SEL;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_TICK;
    now_ms_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing running yet: a tick, an unused action and starts with equal levels.
    send_item(ACT_TICK, 32'd0);
    send_item(ACT_NONE, 32'hFFFF_FFFF);
    send_item(ACT_RISE, 32'd5);
    send_item(ACT_SET, 32'd6);
    write_config(SEL_BAD, 8'd0, 8'd255, 8'd255);
    send_item(ACT_RISE, 32'd7);
    // With zero duration every tick of a running ramp takes a step.
    write_config(SEL_WARM, 8'd0, 8'd255, 8'd0);
    send_item(ACT_RISE, 32'd100);
    repeat (3) send_item(ACT_TICK, 32'd100);
    // Cold sunset: the clock wraps, the accumulator saturates, then a wrong-way start.
    write_config(SEL_COLD, 8'd255, 8'd0, 8'd255);
    send_item(ACT_SET, 32'hFFFF_FF00);
    send_item(ACT_TICK, 32'h0000_0010);
    send_item(ACT_TICK, 32'h0000_000F);
    send_item(ACT_TICK, 32'h0000_EA6F);
    send_item(ACT_RISE, 32'h0000_EA70);
    // Both channels at half level; the sunset reaches zero and switches the light off.
    write_config(SEL_BOTH, 8'd3, 8'd0, 8'd0);
    send_item(ACT_SET, 32'd0);
    send_item(ACT_TICK, 32'd1);
    send_item(ACT_TICK, 32'd2);
    write_config(SEL_COLD, 8'd254, 8'd255, 8'd0);
    send_item(ACT_RISE, 32'd0);
    send_item(ACT_TICK, 32'd0);

    phase_no = 0;
    while (sent < ITEM_TARGET) begin
      random_phase(phase_no);
      phase_no++;
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
